[hdl/tmcg_pkg.sv]
// Shared types and constants of the text mode character generator.
`timescale 1ns / 1ps
`default_nettype none

package tmcg_pkg;

    localparam logic [2:0] REQ_DISP_WR  = 3'd0;
    localparam logic [2:0] REQ_GLYPH_WR = 3'd1;
    localparam logic [2:0] REQ_PORT_WR  = 3'd2;
    localparam logic [2:0] REQ_PORT_RD  = 3'd3;
    localparam logic [2:0] REQ_VBLANK   = 3'd4;
    localparam logic [2:0] REQ_PIXEL    = 3'd5;

    localparam logic [7:0] PORT_STATUS    = 8'h00;
    localparam logic [7:0] PORT_SCROLL_LO = 8'h04;
    localparam logic [7:0] PORT_SCROLL_HI = 8'h05;
    localparam logic [7:0] PORT_ID_A      = 8'h11;
    localparam logic [7:0] PORT_ID_B      = 8'h19;
    localparam logic [7:0] PORT_NMI_EN    = 8'hf0;

    localparam logic [7:0] STATUS_VALUE = 8'h10;
    localparam logic [7:0] ID_VALUE     = 8'h09;

    localparam int          CELL_LINES = 16;
    localparam int          CELL_DOTS  = 9;
    localparam logic [3:0]  BLANK_DOT  = 4'd8;
    localparam logic [12:0] DIV9_MUL   = 13'd7282;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [8:0]  pixel_row;
        logic [10:0] pixel_col;
    } req_t;

    typedef struct packed {
        logic       pixel_on;
        logic [7:0] read_data;
        logic       nmi_pulse;
    } rsp_t;

    typedef struct packed {
        logic       offscreen;
        logic [4:0] cell_row;
        logic [7:0] cell_col;
        logic [3:0] line;
        logic [3:0] dot;
    } cell_pos_t;

endpackage

`default_nettype wire

[hdl/tmcg_cell_map.sv]
// Pixel coordinate to character cell, glyph line and dot mapping.
`timescale 1ns / 1ps
`default_nettype none

module tmcg_cell_map #(
    parameter int TEXT_COLUMNS = 132,
    parameter int TEXT_ROWS    = 26
) (
    input  wire logic [8:0]           pixel_row,
    input  wire logic [10:0]          pixel_col,
    output tmcg_pkg::cell_pos_t       pos
);
    import tmcg_pkg::*;

    localparam logic [9:0]  ROW_LIMIT = 10'(TEXT_ROWS * CELL_LINES);
    localparam logic [11:0] COL_LIMIT = 12'(TEXT_COLUMNS * CELL_DOTS);

    logic [23:0] col_prod;
    logic [7:0]  col_quot;
    logic [10:0] col_base;
    logic [10:0] col_rem;

    // col / 9 by reciprocal multiply, exact for any 11-bit column
    assign col_prod = 24'(pixel_col) * 24'(DIV9_MUL);
    assign col_quot = col_prod[23:16];
    assign col_base = {col_quot, 3'b000} + 11'(col_quot);
    assign col_rem  = pixel_col - col_base;

    assign pos.offscreen = ({1'b0, pixel_row} >= ROW_LIMIT) || ({1'b0, pixel_col} >= COL_LIMIT);
    assign pos.cell_row  = pixel_row[8:4];
    assign pos.line      = pixel_row[3:0];
    assign pos.cell_col  = col_quot;
    assign pos.dot       = col_rem[3:0];

endmodule

`default_nettype wire

[hdl/text_mode_character_generator.sv]
// Top level of the text mode character generator: port decode, display and glyph memories.
`timescale 1ns / 1ps
`default_nettype none

// Takes one request word per cycle and returns exactly one response word for each, in order.
// The four stages are: cell mapping, scroll/port logic with the display RAM read, the glyph
// RAM read, and dot selection into the response register. Memory writes are done in the same
// stage as the reads of that memory, so a pixel request always sees every earlier write. The
// whole pipeline holds only while a response waits and rsp_ready is low. DISPLAY_BYTES and
// GLYPH_BYTES must be powers of two, which the block itself does not enforce; addresses wrap
// within them.
module text_mode_character_generator #(
    parameter int TEXT_COLUMNS  = 132,
    parameter int TEXT_ROWS     = 26,
    parameter int DISPLAY_BYTES = 65536,
    parameter int GLYPH_BYTES   = 16384
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire tmcg_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output tmcg_pkg::rsp_t      rsp
);
    import tmcg_pkg::*;

    localparam int DA = $clog2(DISPLAY_BYTES);
    localparam int GA = $clog2(GLYPH_BYTES);

    logic [7:0] display_ram [DISPLAY_BYTES];
    logic [7:0] glyph_ram   [GLYPH_BYTES];

    logic       adv;
    cell_pos_t  cell_pos;

    logic       s1_valid_reg;
    req_t       s1_req_reg;
    cell_pos_t  s1_pos_reg;

    logic [15:0] scroll_reg, scroll_next;
    logic        nmi_en_reg, nmi_en_next;
    logic [7:0]  port_rd_value;
    logic        nmi_value;
    logic [12:0] row_base;
    logic [16:0] pos_sum;
    logic [DA-1:0] disp_rd_addr;

    logic          s2_valid_reg;
    logic [2:0]    s2_kind_reg;
    logic [GA-1:0] s2_addr_reg;
    logic [7:0]    s2_data_reg;
    logic [3:0]    s2_line_reg;
    logic [3:0]    s2_dot_reg;
    logic          s2_blank_reg;
    logic [7:0]    s2_read_reg;
    logic          s2_nmi_reg;
    logic [7:0]    code_reg;
    logic [12:0]   glyph_idx;
    logic [GA-1:0] glyph_rd_addr;

    logic       s3_valid_reg;
    logic       s3_sel_reg;
    logic [3:0] s3_dot_reg;
    logic [7:0] s3_read_reg;
    logic       s3_nmi_reg;
    logic [7:0] glyph_reg;

    logic       rsp_valid_reg;
    rsp_t       rsp_reg;

    assign adv       = !rsp_valid_reg || rsp_ready;
    assign req_ready = adv;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    tmcg_cell_map #(
        .TEXT_COLUMNS (TEXT_COLUMNS),
        .TEXT_ROWS    (TEXT_ROWS)
    ) u_cell_map (
        .pixel_row (req.pixel_row),
        .pixel_col (req.pixel_col),
        .pos       (cell_pos)
    );

    always_comb
    begin
        scroll_next   = scroll_reg;
        nmi_en_next   = nmi_en_reg;
        port_rd_value = 8'h00;
        nmi_value     = 1'b0;
        if (s1_valid_reg)
        begin
            unique case (s1_req_reg.req_type)
                REQ_PORT_WR:
                begin
                    priority if (s1_req_reg.addr[7:0] == PORT_SCROLL_LO)
                    begin
                        scroll_next = {scroll_reg[15:8], s1_req_reg.data};
                    end
                    else if (s1_req_reg.addr[7:0] == PORT_SCROLL_HI)
                    begin
                        scroll_next = {s1_req_reg.data, scroll_reg[7:0]};
                    end
                    else if (s1_req_reg.addr[7:0] == PORT_NMI_EN)
                    begin
                        nmi_en_next = 1'b1;
                    end
                    else
                    begin
                        scroll_next = scroll_reg;
                    end
                end
                REQ_PORT_RD:
                begin
                    priority if (s1_req_reg.addr[7:0] == PORT_STATUS)
                    begin
                        port_rd_value = STATUS_VALUE;
                    end
                    else if (s1_req_reg.addr[7:0] == PORT_ID_A
                             || s1_req_reg.addr[7:0] == PORT_ID_B)
                    begin
                        port_rd_value = ID_VALUE;
                    end
                    else
                    begin
                        port_rd_value = 8'h00;
                    end
                end
                REQ_VBLANK:
                begin
                    nmi_value = nmi_en_reg;
                end
                default:
                begin
                    nmi_value = 1'b0;
                end
            endcase
        end
    end

    assign row_base      = 13'(s1_pos_reg.cell_row) * 13'(TEXT_COLUMNS);
    assign pos_sum       = 17'(scroll_reg) + 17'(row_base) + 17'(s1_pos_reg.cell_col);
    assign disp_rd_addr  = pos_sum[DA-1:0];

    assign glyph_idx     = {code_reg, 1'b0, s2_line_reg};
    assign glyph_rd_addr = GA'(glyph_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            scroll_reg    <= 16'h0000;
            nmi_en_reg    <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= req_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            rsp_valid_reg <= s3_valid_reg;
            scroll_reg    <= scroll_next;
            nmi_en_reg    <= nmi_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_req_reg   <= req;
            s1_pos_reg   <= cell_pos;

            s2_kind_reg  <= s1_valid_reg ? s1_req_reg.req_type : REQ_DISP_WR;
            s2_addr_reg  <= s1_req_reg.addr[GA-1:0];
            s2_data_reg  <= s1_req_reg.data;
            s2_line_reg  <= s1_pos_reg.line;
            s2_dot_reg   <= s1_pos_reg.dot;
            s2_blank_reg <= s1_pos_reg.offscreen || (s1_pos_reg.dot == BLANK_DOT);
            s2_read_reg  <= port_rd_value;
            s2_nmi_reg   <= nmi_value;

            s3_sel_reg   <= s2_valid_reg && (s2_kind_reg == REQ_PIXEL) && !s2_blank_reg;
            s3_dot_reg   <= s2_dot_reg;
            s3_read_reg  <= s2_read_reg;
            s3_nmi_reg   <= s2_nmi_reg;

            rsp_reg.pixel_on  <= s3_sel_reg && glyph_reg[~s3_dot_reg[2:0]];
            rsp_reg.read_data <= s3_read_reg;
            rsp_reg.nmi_pulse <= s3_nmi_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (s1_valid_reg && (s1_req_reg.req_type == REQ_DISP_WR))
            begin
                display_ram[s1_req_reg.addr[DA-1:0]] <= s1_req_reg.data;
            end
            code_reg <= display_ram[disp_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (s2_valid_reg && (s2_kind_reg == REQ_GLYPH_WR))
            begin
                glyph_ram[s2_addr_reg] <= s2_data_reg;
            end
            glyph_reg <= glyph_ram[glyph_rd_addr];
        end
    end

`ifndef NO_ASSERTIONS
    a_nmi_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.nmi_pulse |-> nmi_en_reg)
        else $error("nmi pulse without nmi enabled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request side stalled with empty response register");

    a_read_values: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.read_data == 8'h00 || rsp.read_data == STATUS_VALUE
                       || rsp.read_data == ID_VALUE))
        else $error("unexpected port read value");

    a_one_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $countones({rsp.pixel_on, |rsp.read_data, rsp.nmi_pulse}) <= 1)
        else $error("response carries more than one kind of result");
`endif

endmodule

`default_nettype wire
